>>> sv/nntt_pkg.sv
// Package with shared types and constants of the track table.
`default_nettype none
package nntt_pkg;

    localparam int MAX_TRACKS_DEF = 16;
    localparam int COORD_BITS_DEF = 20;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 44;
    localparam int DIST_BITS = 44;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ASSOC = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [2:0] KIND_MATCHED = 3'd0;
    localparam logic [2:0] KIND_NEW = 3'd1;
    localparam logic [2:0] KIND_DROPPED = 3'd2;
    localparam logic [2:0] KIND_REPORT = 3'd3;
    localparam logic [2:0] KIND_NONE = 3'd4;

    typedef struct packed {
        logic               mode;
        logic [31:0]        now_time;
        logic signed [19:0] det_x;
        logic signed [19:0] det_y;
        logic signed [19:0] det_z;
        logic [15:0]        det_radius;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [15:0]        track_id;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic [15:0]        radius_out;
        logic [15:0]        hits;
        logic               is_confirmed;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic [15:0]        radius;
        logic [31:0]        seen;
        logic [15:0]        hits;
        logic               confirmed;
    } track_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRD,
        ST_SDIST,
        ST_SCMP,
        ST_MRD,
        ST_MMUL,
        ST_MWR,
        ST_CRD,
        ST_CCHK,
        ST_RRD,
        ST_RCHK,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

>>> sv/nearest_neighbor_track_table.sv
// Top level of the nearest-neighbor track table.
//   Channel  | Direction | Handshake         | Payload
//   in       | input     | in_valid/in_ready | in_item_t
//   out      | output    | out_valid/out_ready | out_item_t
//   cfg      | input     | cfg_we            | cfg_index, cfg_data
// An item is accepted while the block is idle and the output is free. The search of a
// detection skips each track already matched in the frame and reads each other stored
// track through the single read port of the track memory to compare its distance, then
// updates the best match or appends a new track or drops the detection. An end-of-frame
// item compacts the table and reports confirmed tracks. A waiting output stalls the block.
// Reset clears the control state, track count, identifier counter and matched bits.
`default_nettype none
module nearest_neighbor_track_table #(
    parameter int MAX_TRACKS = nntt_pkg::MAX_TRACKS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire nntt_pkg::in_item_t                   in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output nntt_pkg::out_item_t                       out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [nntt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [nntt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import nntt_pkg::*;

    localparam int AW = $clog2(MAX_TRACKS);
    localparam int CW = $clog2(MAX_TRACKS + 1);

    logic [43:0] assoc_reg;
    logic [16:0] alpha_reg;
    logic [7:0]  confirm_reg;
    logic [31:0] timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assoc_reg   <= 44'd250000;
            alpha_reg   <= 17'd19661;
            confirm_reg <= 8'd3;
            timeout_reg <= 32'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ASSOC:   assoc_reg <= cfg_data;
                CFG_ALPHA:   alpha_reg <= cfg_data[16:0];
                CFG_CONFIRM: confirm_reg <= cfg_data[7:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wptr_reg, wptr_next;
    logic [15:0] nid_reg, nid_next;
    logic [MAX_TRACKS-1:0] matched_reg, matched_next;
    logic [DIST_BITS-1:0] best_d_reg, best_d_next;
    logic [AW-1:0] best_reg, best_next;
    logic found_reg, found_next;
    logic [DIST_BITS-1:0] dist_reg;
    logic last_pending_reg, last_pending_next;
    out_item_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    track_t hold_reg, hold_next;
    logic signed [37:0] px_reg, py_reg, pz_reg, pr_reg;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    track_t mem_wdata, rd;

    nntt_mem #(.MAX_TRACKS(MAX_TRACKS), .AW(AW)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(rd)
    );

    function automatic logic [22:0] absd(input logic signed [19:0] a,
                                         input logic signed [19:0] b);
        logic signed [20:0] d;
        begin
            d = 21'(a) - 21'(b);
            absd = d[20] ? 23'(-d) : 23'(d);
        end
    endfunction

    logic [22:0] ax, ay, az;
    logic [16:0] a_sat, a_inv;
    assign ax = absd(item_reg.det_x, rd.x);
    assign ay = absd(item_reg.det_y, rd.y);
    assign az = absd(item_reg.det_z, rd.z);
    assign a_sat = alpha_reg > 17'd65536 ? 17'd65536 : alpha_reg;
    assign a_inv = 17'd65536 - a_sat;

    always_ff @(posedge clk)
    begin
        dist_reg <= 44'(ax) * 44'(ax) + 44'(ay) * 44'(ay) + 44'(az) * 44'(az);
        px_reg <= $signed({1'b0, a_inv}) * rd.x
                + $signed({1'b0, a_sat}) * item_reg.det_x + 38'sd32768;
        py_reg <= $signed({1'b0, a_inv}) * rd.y
                + $signed({1'b0, a_sat}) * item_reg.det_y + 38'sd32768;
        pz_reg <= $signed({1'b0, a_inv}) * rd.z
                + $signed({1'b0, a_sat}) * item_reg.det_z + 38'sd32768;
        pr_reg <= $signed({1'b0, a_inv}) * $signed({1'b0, rd.radius})
                + $signed({1'b0, a_sat}) * $signed({1'b0, item_reg.det_radius})
                + 38'sd32768;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            wptr_reg         <= '0;
            nid_reg          <= '0;
            matched_reg      <= '0;
            found_reg        <= 1'b0;
            last_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            wptr_reg         <= wptr_next;
            nid_reg          <= nid_next;
            matched_reg      <= matched_next;
            found_reg        <= found_next;
            last_pending_reg <= last_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        best_d_reg <= best_d_next;
        best_reg   <= best_next;
        out_reg    <= out_next;
        hold_reg   <= hold_next;
    end

    function automatic out_item_t mk(input logic [2:0] k, input track_t t,
                                     input logic last);
        out_item_t o;
        begin
            o.kind = k;
            o.track_id = t.id;
            o.pos_x = t.x;
            o.pos_y = t.y;
            o.pos_z = t.z;
            o.radius_out = t.radius;
            o.hits = t.hits;
            o.is_confirmed = t.confirmed;
            o.last_of_run = last;
            mk = o;
        end
    endfunction

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign in_ready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        track_t t;
        logic [15:0] h;
        t = hold_reg;
        h = '0;
        state_next = state_reg;
        item_next = item_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        wptr_next = wptr_reg;
        nid_next = nid_reg;
        matched_next = matched_reg;
        best_d_next = best_d_reg;
        best_next = best_reg;
        found_next = found_reg;
        last_pending_next = last_pending_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hold_next = hold_reg;
        mem_we = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = hold_reg;
        mem_raddr = idx_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next = in_data;
                    idx_next = '0;
                    wptr_next = '0;
                    found_next = 1'b0;
                    best_d_next = assoc_reg;
                    state_next = in_data.mode ? ST_CRD : ST_SRD;
                end
            end
            ST_SRD:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = found_reg ? ST_MRD : ST_OUT;
                end
                else if (matched_reg[idx_reg[AW-1:0]])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_SDIST;
                end
            end
            ST_SDIST: state_next = ST_SCMP;
            ST_SCMP:
            begin
                if (dist_reg < best_d_reg)
                begin
                    best_d_next = dist_reg;
                    best_next = idx_reg[AW-1:0];
                    found_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                state_next = ST_SRD;
            end
            ST_MRD:
            begin
                mem_raddr = best_reg;
                state_next = ST_MMUL;
            end
            ST_MMUL:
            begin
                mem_raddr = best_reg;
                hold_next = rd;
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                mem_raddr = best_reg;
                if (out_free)
                begin
                    t = hold_reg;
                    t.x = px_reg[35:16];
                    t.y = py_reg[35:16];
                    t.z = pz_reg[35:16];
                    t.radius = pr_reg[31:16];
                    t.seen = item_reg.now_time;
                    h = (hold_reg.hits == 16'hFFFF) ? hold_reg.hits : hold_reg.hits + 1'b1;
                    t.hits = h;
                    if ({8'd0, confirm_reg} <= h)
                    begin
                        t.confirmed = 1'b1;
                    end
                    mem_we = 1'b1;
                    mem_waddr = best_reg;
                    mem_wdata = t;
                    matched_next[best_reg] = 1'b1;
                    out_next = mk(KIND_MATCHED, t, 1'b1);
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    t.x = item_reg.det_x;
                    t.y = item_reg.det_y;
                    t.z = item_reg.det_z;
                    t.radius = item_reg.det_radius;
                    t.seen = item_reg.now_time;
                    if (count_reg < CW'(MAX_TRACKS))
                    begin
                        t.id = nid_reg;
                        t.hits = 16'd1;
                        t.confirmed = confirm_reg <= 8'd1;
                        mem_we = 1'b1;
                        mem_waddr = count_reg[AW-1:0];
                        mem_wdata = t;
                        matched_next[count_reg[AW-1:0]] = 1'b1;
                        count_next = count_reg + 1'b1;
                        nid_next = nid_reg + 1'b1;
                        out_next = mk(KIND_NEW, t, 1'b1);
                    end
                    else
                    begin
                        t.id = '0;
                        t.hits = '0;
                        t.confirmed = 1'b0;
                        out_next = mk(KIND_DROPPED, t, 1'b1);
                    end
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CRD:
            begin
                matched_next = '0;
                if (idx_reg >= count_reg)
                begin
                    count_next = wptr_reg;
                    idx_next = '0;
                    last_pending_next = 1'b0;
                    state_next = ST_RRD;
                end
                else
                begin
                    state_next = ST_CCHK;
                end
            end
            ST_CCHK:
            begin
                if (item_reg.now_time - rd.seen <= timeout_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = wptr_reg[AW-1:0];
                    mem_wdata = rd;
                    wptr_next = wptr_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                state_next = ST_CRD;
            end
            ST_RRD:
            begin
                if (idx_reg >= count_reg)
                begin
                    if (out_free)
                    begin
                        if (last_pending_reg)
                        begin
                            out_next = mk(KIND_REPORT, hold_reg, 1'b1);
                        end
                        else
                        begin
                            out_next = '0;
                            out_next.kind = KIND_NONE;
                            out_next.last_of_run = 1'b1;
                        end
                        out_valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_RCHK;
                end
            end
            ST_RCHK:
            begin
                if (!rd.confirmed)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_RRD;
                end
                else if (!last_pending_reg)
                begin
                    hold_next = rd;
                    last_pending_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_RRD;
                end
                else if (out_free)
                begin
                    out_next = mk(KIND_REPORT, hold_reg, 1'b0);
                    out_valid_next = 1'b1;
                    hold_next = rd;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_RRD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/nntt_mem.sv
// Track storage memory with one write port and one registered read port.
`default_nettype none
module nntt_mem #(
    parameter int MAX_TRACKS = nntt_pkg::MAX_TRACKS_DEF,
    parameter int AW = $clog2(MAX_TRACKS)
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire nntt_pkg::track_t    wdata,
    input  wire logic [AW-1:0]       raddr,
    output nntt_pkg::track_t         rdata
);
    import nntt_pkg::*;

    track_t mem [MAX_TRACKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for the nearest-neighbor track table: directed and random items checked against a predictor.
`timescale 1ns / 100ps
module tb;
    import nntt_pkg::*;

    localparam int NTRK = 16;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    nearest_neighbor_track_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    track_t tracks [NTRK];
    logic matched [NTRK];
    int track_count;
    logic [15:0] next_id;
    logic [43:0] assoc_limit;
    logic [16:0] alpha;
    logic [7:0] confirm_at;
    logic [31:0] timeout;

    out_item_t expected_q [$];
    int errors;
    int idle_cycles;
    bit hold_off;
    logic [31:0] frame_time;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic queue_result(input out_item_t r);
        expected_q = {expected_q, r};
    endtask

    function automatic logic [45:0] axis_sq(input logic signed [19:0] a,
                                            input logic signed [19:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        if (d > (64'sd1 << 22)) d = 64'sd1 << 22;
        return 46'(d * d);
    endfunction

    function automatic longint smoothed(input longint old, input longint det, input longint a);
        longint s;
        s = (65536 - a) * old + a * det + 32768 + (64'sd1 << 52);
        return longint'(64'(s) >> 16) - (64'sd1 << 36);
    endfunction

    function automatic out_item_t track_result(input logic [2:0] kind, input int i,
                                               input logic last);
        out_item_t r;
        r.kind = kind;
        r.track_id = tracks[i].id;
        r.pos_x = tracks[i].x;
        r.pos_y = tracks[i].y;
        r.pos_z = tracks[i].z;
        r.radius_out = tracks[i].radius;
        r.hits = tracks[i].hits;
        r.is_confirmed = tracks[i].confirmed;
        r.last_of_run = last;
        return r;
    endfunction

    task automatic predict(input in_item_t it);
        int w;
        int last;
        int best;
        logic [47:0] best_d;
        logic [47:0] d;
        longint a;
        out_item_t r;
        if (it.mode)
        begin
            w = 0;
            last = -1;
            for (int i = 0; i < track_count; i++)
            begin
                if ((it.now_time - tracks[i].seen) > timeout) continue;
                tracks[w] = tracks[i];
                w++;
            end
            track_count = w;
            for (int i = 0; i < NTRK; i++) matched[i] = 1'b0;
            for (int i = 0; i < track_count; i++)
                if (tracks[i].confirmed) last = i;
            if (last < 0)
            begin
                r = '0;
                r.kind = KIND_NONE;
                r.last_of_run = 1'b1;
                queue_result(r);
            end
            else
                for (int i = 0; i < track_count; i++)
                    if (tracks[i].confirmed)
                        queue_result(track_result(KIND_REPORT, i, i == last));
            return;
        end
        best_d = 48'(assoc_limit);
        best = -1;
        for (int i = 0; i < track_count; i++)
        begin
            if (matched[i]) continue;
            d = 48'(axis_sq(it.det_x, tracks[i].x)) + 48'(axis_sq(it.det_y, tracks[i].y))
                + 48'(axis_sq(it.det_z, tracks[i].z));
            if (d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        if (best >= 0)
        begin
            a = (alpha > 17'd65536) ? 65536 : longint'(alpha);
            tracks[best].seen = it.now_time;
            if (tracks[best].hits != 16'hFFFF) tracks[best].hits++;
            if (tracks[best].hits >= 16'(confirm_at)) tracks[best].confirmed = 1'b1;
            tracks[best].radius = 16'(smoothed(tracks[best].radius, it.det_radius, a));
            tracks[best].x = 20'(smoothed(tracks[best].x, it.det_x, a));
            tracks[best].y = 20'(smoothed(tracks[best].y, it.det_y, a));
            tracks[best].z = 20'(smoothed(tracks[best].z, it.det_z, a));
            matched[best] = 1'b1;
            queue_result(track_result(KIND_MATCHED, best, 1'b1));
        end
        else if (track_count < NTRK)
        begin
            tracks[track_count].id = next_id;
            next_id++;
            tracks[track_count].x = it.det_x;
            tracks[track_count].y = it.det_y;
            tracks[track_count].z = it.det_z;
            tracks[track_count].radius = it.det_radius;
            tracks[track_count].seen = it.now_time;
            tracks[track_count].hits = 16'd1;
            tracks[track_count].confirmed = confirm_at <= 8'd1;
            matched[track_count] = 1'b1;
            queue_result(track_result(KIND_NEW, track_count, 1'b1));
            track_count++;
        end
        else
        begin
            r = '0;
            r.kind = KIND_DROPPED;
            r.pos_x = it.det_x;
            r.pos_y = it.det_y;
            r.pos_z = it.det_z;
            r.radius_out = it.det_radius;
            r.last_of_run = 1'b1;
            queue_result(r);
        end
    endtask

    task automatic send_item(input in_item_t it, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict(it);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [43:0] val);
        in_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_ASSOC: assoc_limit = val;
            CFG_ALPHA: alpha = val[16:0];
            CFG_CONFIRM: confirm_at = val[7:0];
            default: timeout = val[31:0];
        endcase
    endtask

    function automatic in_item_t detection(input logic signed [19:0] x,
                                           input logic signed [19:0] y,
                                           input logic signed [19:0] z,
                                           input logic [15:0] rad);
        in_item_t it;
        it.mode = 1'b0;
        it.now_time = frame_time;
        it.det_x = x;
        it.det_y = y;
        it.det_z = z;
        it.det_radius = rad;
        return it;
    endfunction

    function automatic in_item_t frame_end(input logic [31:0] t);
        in_item_t it;
        it = '0;
        it.mode = 1'b1;
        it.now_time = t;
        it.det_x = 20'($urandom);
        it.det_y = 20'($urandom);
        it.det_z = 20'($urandom);
        it.det_radius = 16'($urandom);
        return it;
    endfunction

    task automatic test_directed();
        send_item(frame_end(32'd0));
        send_item(detection(20'sd0, 20'sd0, 20'sd0, 16'd0));
        send_item(detection(20'sd10, 20'sd0, 20'sd0, 16'hFFFF));
        send_item(detection(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 16'd100));
        send_item(detection(20'sh80000, 20'sh7FFFF, 20'sh80000, 16'd7));
        send_item(frame_end(frame_time));
        for (int k = 0; k < 3; k++)
        begin
            frame_time += 10;
            send_item(detection(20'sd3, 20'sd1, 20'sd0, 16'd50));
            send_item(detection(20'sh7FFFE, 20'sh80001, 20'sh7FFFF, 16'd90));
            send_item(frame_end(frame_time));
        end
        wait_drain();
        write_reg(CFG_TIMEOUT, 44'd0);
        send_item(frame_end(frame_time + 1));
        wait_drain();
    endtask

    task automatic test_full_table();
        write_reg(CFG_ASSOC, 44'd0);
        write_reg(CFG_CONFIRM, 44'd1);
        write_reg(CFG_TIMEOUT, 44'hFFFFFFFF);
        for (int k = 0; k < 19; k++)
            send_item(detection(20'(k * 1000), 20'(-k), 20'sd5, 16'(k)));
        send_item(frame_end(frame_time + 32'hF0000000));
        wait_drain();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_TIMEOUT, 44'd0);
        send_item(frame_end(frame_time));
        wait_drain();
        write_reg(CFG_ASSOC, 44'hFFFFFFFFFFF);
        write_reg(CFG_ALPHA, 44'd65536);
        write_reg(CFG_CONFIRM, 44'd0);
        write_reg(CFG_TIMEOUT, 44'd100);
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 10; k++)
                send_item(detection(20'($urandom), 20'($urandom), 20'($urandom),
                                    16'($urandom)), 1);
        join
        send_item(frame_end(frame_time + 50));
        wait_drain();
    endtask

    task automatic test_random();
        logic [43:0] limits [4] = '{44'd0, 44'd250000, 44'd40000000, 44'hFFFFFFFFFFF};
        logic [16:0] alphas [4] = '{17'd0, 17'd19661, 17'd65536, 17'h1FFFF};
        int sent;
        int per_frame;
        int spread;
        sent = 0;
        for (int phase = 0; sent < 200; phase++)
        begin
            write_reg(CFG_ASSOC, limits[phase % 4]);
            write_reg(CFG_ALPHA, (phase % 5 == 4) ? 44'($urandom_range(0, 131071))
                                                  : 44'(alphas[(phase / 4) % 4]));
            write_reg(CFG_CONFIRM, (phase % 7 == 6) ? 44'd255 : 44'($urandom_range(0, 4)));
            write_reg(CFG_TIMEOUT, (phase % 6 == 5) ? 44'hFFFFFFFF
                                                    : 44'($urandom_range(0, 60)));
            spread = (phase % 3 == 0) ? 524287 : 3000;
            for (int f = 0; f < 4; f++)
            begin
                per_frame = $urandom_range(0, 8);
                frame_time += $urandom_range(0, 40);
                if ($urandom_range(0, 15) == 0) frame_time = 32'hFFFFFFF0;
                for (int k = 0; k < per_frame; k++)
                begin
                    send_item(detection(
                        20'($signed($urandom_range(0, 2 * spread)) - spread),
                        20'($signed($urandom_range(0, 2 * spread)) - spread),
                        ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'sd0,
                        16'($urandom)));
                    sent++;
                end
                send_item(($urandom_range(0, 9) == 0) ? frame_end($urandom) :
                          frame_end(frame_time));
                sent++;
            end
            wait_drain();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 12) == 0);
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected transfer", 64'(out_data), 64'd0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.kind !== want.kind)
                    report_mismatch("kind", 64'(out_data.kind), 64'(want.kind));
                if (out_data.track_id !== want.track_id)
                    report_mismatch("track_id", 64'(out_data.track_id), 64'(want.track_id));
                if (out_data.pos_x !== want.pos_x)
                    report_mismatch("pos_x", 64'(out_data.pos_x), 64'(want.pos_x));
                if (out_data.pos_y !== want.pos_y)
                    report_mismatch("pos_y", 64'(out_data.pos_y), 64'(want.pos_y));
                if (out_data.pos_z !== want.pos_z)
                    report_mismatch("pos_z", 64'(out_data.pos_z), 64'(want.pos_z));
                if (out_data.radius_out !== want.radius_out)
                    report_mismatch("radius_out", 64'(out_data.radius_out),
                                    64'(want.radius_out));
                if (out_data.hits !== want.hits)
                    report_mismatch("hits", 64'(out_data.hits), 64'(want.hits));
                if (out_data.is_confirmed !== want.is_confirmed)
                    report_mismatch("is_confirmed", 64'(out_data.is_confirmed),
                                    64'(want.is_confirmed));
                if (out_data.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 64'(out_data.last_of_run),
                                    64'(want.last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_ready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        frame_time = 32'd500;
        track_count = 0;
        next_id = '0;
        for (int i = 0; i < NTRK; i++) matched[i] = 1'b0;
        assoc_limit = 44'd250000;
        alpha = 17'd19661;
        confirm_at = 8'd3;
        timeout = 32'd1000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random();
        wait_drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
